// ----- src/dsdd_pkg.sv -----
// Shared types, character codes and month tables for the date difference block.
// No dependencies; used by every module under src.
package dsdd_pkg;

  // Character codes of the two separators and of the digits zero and nine.
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Field select codes.
  localparam logic [1:0] FIELD_DAY   = 2'd0;
  localparam logic [1:0] FIELD_MONTH = 2'd1;
  localparam logic [1:0] FIELD_YEAR  = 2'd2;

  // Digit limits per field.
  localparam logic [2:0] DAY_DIGITS   = 3'd2;
  localparam logic [2:0] MONTH_DIGITS = 3'd2;
  localparam logic [2:0] YEAR_DIGITS  = 3'd5;

  localparam int DAY_W    = 7;
  localparam int MONTH_W  = 7;
  localparam int YEAR_W   = 17;
  localparam int COUNT_W  = 22;
  localparam int TOTAL_W  = 26;
  localparam int REST_W   = 16;
  localparam int DIFF_W   = 23;
  localparam int FLAGS_W  = 3;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 17'd10000;
  localparam logic [8:0]        DAYS_PER_YEAR = 9'd365;

  // Error flag bits.
  localparam int FLAG_YEAR  = 0;
  localparam int FLAG_MONTH = 1;
  localparam int FLAG_DAY   = 2;

  // One parsed date handed from the parser to the counter.
  typedef struct packed {
    logic                 second;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
  } date_t;

  // Days of the months before month index (0 = January), non-leap year.
  function automatic logic [8:0] days_before(input logic [3:0] idx);
    logic [8:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of month index (0 = January), non-leap year.
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] r;
    unique case (idx)
      4'd1:                          r = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:       r = 5'd30;
      default:                       r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ----- src/dsdd_parser.sv -----
// Front end: takes one character per cycle while the queue is not full, builds day, month and year values.
// Pushes a dsdd_pkg::date_t record into the queue on the last character of a date.
module dsdd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          ch,
  input  logic                end_of_date,
  input  logic                full,
  output logic                push,
  output dsdd_pkg::date_t     push_data
);

  logic                              phase;
  logic [1:0]                        field_select, field_select_next;
  logic [2:0]                        digit_count, digit_count_next;
  logic [dsdd_pkg::DAY_W-1:0]        day_value, day_value_next;
  logic [dsdd_pkg::MONTH_W-1:0]      month_value, month_value_next;
  logic [dsdd_pkg::YEAR_W-1:0]       year_value, year_value_next;

  logic       is_sep, is_digit, accept;
  logic [3:0] digit;
  logic [9:0] day_mul, month_mul;
  logic [19:0] year_mul;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign is_sep   = (ch == dsdd_pkg::CH_SLASH) || (ch == dsdd_pkg::CH_DASH);
  assign is_digit = (ch >= dsdd_pkg::CH_ZERO) && (ch <= dsdd_pkg::CH_NINE);
  // low nibble of an ASCII digit is its value
  assign digit    = ch[3:0];

  assign day_mul   = (10'(day_value) << 3) + (10'(day_value) << 1) + 10'(digit);
  assign month_mul = (10'(month_value) << 3) + (10'(month_value) << 1) + 10'(digit);
  assign year_mul  = (20'(year_value) << 3) + (20'(year_value) << 1) + 20'(digit);

  // Field update for the current character
  always_comb begin
    field_select_next = field_select;
    digit_count_next  = digit_count;
    day_value_next    = day_value;
    month_value_next  = month_value;
    year_value_next   = year_value;
    if (is_sep) begin
      if (field_select != dsdd_pkg::FIELD_YEAR) begin
        field_select_next = field_select + 2'd1;
        digit_count_next  = 3'd0;
      end
    end else if (is_digit) begin
      unique case (field_select)
        dsdd_pkg::FIELD_DAY: begin
          if (digit_count < dsdd_pkg::DAY_DIGITS) begin
            day_value_next   = day_mul[dsdd_pkg::DAY_W-1:0];
            digit_count_next = digit_count + 3'd1;
          end
        end
        dsdd_pkg::FIELD_MONTH: begin
          if (digit_count < dsdd_pkg::MONTH_DIGITS) begin
            month_value_next = month_mul[dsdd_pkg::MONTH_W-1:0];
            digit_count_next = digit_count + 3'd1;
          end
        end
        default: begin
          if (digit_count < dsdd_pkg::YEAR_DIGITS) begin
            year_value_next  = year_mul[dsdd_pkg::YEAR_W-1:0];
            digit_count_next = digit_count + 3'd1;
          end
        end
      endcase
    end
  end

  // Finished date goes to the queue with the last character applied
  assign push             = accept && end_of_date;
  assign push_data.second = phase;
  assign push_data.day    = day_value_next;
  assign push_data.month  = month_value_next;
  assign push_data.year   = year_value_next;

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      field_select <= dsdd_pkg::FIELD_DAY;
      digit_count  <= 3'd0;
      day_value    <= '0;
      month_value  <= '0;
      year_value   <= '0;
    end else if (accept) begin
      if (end_of_date) begin
        phase        <= !phase;
        field_select <= dsdd_pkg::FIELD_DAY;
        digit_count  <= 3'd0;
        day_value    <= '0;
        month_value  <= '0;
        year_value   <= '0;
      end else begin
        field_select <= field_select_next;
        digit_count  <= digit_count_next;
        day_value    <= day_value_next;
        month_value  <= month_value_next;
        year_value   <= year_value_next;
      end
    end
  end

endmodule

// ----- src/dsdd_fifo.sv -----
// Short register queue of parsed dates between parser and counter.
// Uses dsdd_pkg::date_t.
module dsdd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dsdd_pkg::date_t push_data,
  input  logic            pop,
  output dsdd_pkg::date_t head,
  output logic            empty,
  output logic            full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsdd_pkg::date_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/dsdd_counter.sv -----
// Back end: turns parsed dates into day counts in two stages and forms the result.
// Uses dsdd_pkg tables and date_t; holds the first date's count and flags.
module dsdd_counter (
  input  logic                                clk,
  input  logic                                rst,
  input  dsdd_pkg::date_t                     head,
  input  logic                                empty,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dsdd_pkg::DIFF_W-1:0]  day_difference,
  output logic [dsdd_pkg::FLAGS_W-1:0]        error_flags
);

  logic enable;

  // Stage A signals
  logic                               leap, month_ok, year_nz;
  logic [3:0]                         midx;
  logic [14:0]                        leap_days;
  logic [8:0]                         month_days;
  logic [4:0]                         len;
  logic [dsdd_pkg::FLAGS_W-1:0]       flags_next;
  logic [dsdd_pkg::REST_W-1:0]        rest_next;
  logic [dsdd_pkg::TOTAL_W-1:0]       prod_next;

  logic                               a_valid, a_second;
  logic [dsdd_pkg::TOTAL_W-1:0]       a_prod;
  logic [dsdd_pkg::REST_W-1:0]        a_rest;
  logic [dsdd_pkg::FLAGS_W-1:0]       a_flags;

  // Stage B signals
  logic [dsdd_pkg::TOTAL_W-1:0]       total;
  logic [dsdd_pkg::COUNT_W-1:0]       count;
  logic [dsdd_pkg::COUNT_W-1:0]       first_count;
  logic [dsdd_pkg::FLAGS_W-1:0]       err_accum;

  // The pipeline moves whenever the output register is free or being taken
  assign enable = !out_valid || out_ready;
  assign pop    = enable && !empty;

  // Leap rule, leap days before this year, month offset and length
  always_comb begin
    year_nz  = (head.year != '0);
    leap     = (head.year[1:0] == 2'b00);
    month_ok = (head.month >= 7'd1) && (head.month <= 7'd12);
    midx     = head.month[3:0] - 4'd1;
    leap_days = head.year[dsdd_pkg::YEAR_W-1:2] - 15'(leap && year_nz);
    flags_next = '0;
    if (month_ok) begin
      month_days = dsdd_pkg::days_before(midx) + 9'(leap && (head.month > 7'd2));
      len        = (leap && (head.month == 7'd2)) ? 5'd29 : dsdd_pkg::month_len(midx);
    end else begin
      // month above 12 counts the whole year, month zero counts nothing
      month_days = (head.month > 7'd12) ? (dsdd_pkg::DAYS_PER_YEAR + 9'(leap)) : 9'd0;
      len        = 5'd31;
      flags_next[dsdd_pkg::FLAG_MONTH] = 1'b1;
    end
    flags_next[dsdd_pkg::FLAG_YEAR] = !year_nz || (head.year > dsdd_pkg::YEAR_MAX);
    flags_next[dsdd_pkg::FLAG_DAY]  = (head.day == '0) || (head.day > 7'(len));
    rest_next = 16'(head.day) + 16'(leap_days) + 16'(month_days);
    prod_next = dsdd_pkg::TOTAL_W'(head.year) * dsdd_pkg::TOTAL_W'(dsdd_pkg::DAYS_PER_YEAR);
  end

  // Stage A registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (enable) begin
      a_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_second <= head.second;
      a_prod   <= prod_next;
      a_rest   <= rest_next;
      a_flags  <= flags_next;
    end
  end

  // Stage B: sum and saturate
  assign total = a_prod + dsdd_pkg::TOTAL_W'(a_rest);
  assign count = (total[dsdd_pkg::TOTAL_W-1:dsdd_pkg::COUNT_W] != '0) ? '1 :
                 total[dsdd_pkg::COUNT_W-1:0];

  // Hold first date, emit difference on second
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      first_count <= '0;
      err_accum   <= '0;
    end else if (enable) begin
      out_valid <= a_valid && a_second;
      if (a_valid) begin
        if (!a_second) begin
          first_count <= count;
          err_accum   <= a_flags;
        end else begin
          first_count <= '0;
          err_accum   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable && a_valid && a_second) begin
      day_difference <= signed'(dsdd_pkg::DIFF_W'(count) - dsdd_pkg::DIFF_W'(first_count));
      error_flags    <= err_accum | a_flags;
    end
  end

endmodule

// ----- src/date_string_day_difference.sv -----
// Day difference of two date strings, one character per cycle while in_ready is high.
// The second date, once its last character is accepted, passes the queue, stage A and
// the output register; the result is held while the output stalls. The character rate
// is set by the parser; the counter's two stages take one date per cycle unless stalled.
// Reset (rst, synchronous) returns to the first date's day field with an empty queue.
// Uses dsdd_pkg, dsdd_parser, dsdd_fifo and dsdd_counter.
module date_string_day_difference #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          ch,
  input  logic                                end_of_date,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dsdd_pkg::DIFF_W-1:0]  day_difference,
  output logic [dsdd_pkg::FLAGS_W-1:0]        error_flags
);

  logic            push, pop, empty, full;
  dsdd_pkg::date_t push_data, head;

  // Character parser
  dsdd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .end_of_date (end_of_date),
    .full        (full),
    .push        (push),
    .push_data   (push_data)
  );

  // Queue of parsed dates
  dsdd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Day count and difference
  dsdd_counter u_counter (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .day_difference (day_difference),
    .error_flags    (error_flags)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for date_string_day_difference: sends date strings one character per item
// and checks each day difference and its error flags. Depends on dsdd_pkg and the RTL top.
module tb;

  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CHARS_PER_MIX = 405;
  localparam int unsigned COUNT_CEIL = (1 << dsdd_pkg::COUNT_W) - 1;

  // Tracks the parser state of the block and the day differences still owed.
  class day_diff_scoreboard;
    int unsigned cum_days [12];
    int unsigned days_in  [12];
    bit               in_second;
    logic [1:0]       field;
    int unsigned      ndigits;
    int unsigned      day_acc, month_acc, year_acc;
    int unsigned      first_total;
    logic [dsdd_pkg::FLAGS_W-1:0] flags_acc;
    logic [dsdd_pkg::DIFF_W-1:0]  diff_q [$];
    logic [dsdd_pkg::FLAGS_W-1:0] flags_q [$];
    int errors;
    int checked;

    function new();
      cum_days = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      days_in  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      in_second = 1'b0;
      first_total = 0;
      flags_acc = '0;
      errors = 0;
      checked = 0;
      clear_fields();
    endfunction

    function void clear_fields();
      field = dsdd_pkg::FIELD_DAY;
      ndigits = 0;
      day_acc = 0;
      month_acc = 0;
      year_acc = 0;
    endfunction

    // Day count of the date just parsed; flags out through fl.
    function int unsigned date_total(output logic [dsdd_pkg::FLAGS_W-1:0] fl);
      bit leap;
      int unsigned total, mlen;
      leap = (year_acc % 4) == 0;
      fl = '0;
      total = day_acc + year_acc * 365;
      if (leap) total += (year_acc == 0) ? 0 : (year_acc - 1) / 4;
      else total += year_acc / 4;
      if (month_acc >= 1 && month_acc <= 12) begin
        total += cum_days[month_acc-1];
        if (leap && month_acc > 2) total += 1;
        mlen = (leap && month_acc == 2) ? 29 : days_in[month_acc-1];
      end else begin
        if (month_acc > 12) total += leap ? 366 : 365;
        mlen = 31;
        fl[dsdd_pkg::FLAG_MONTH] = 1'b1;
      end
      if (year_acc < 1 || year_acc > dsdd_pkg::YEAR_MAX) fl[dsdd_pkg::FLAG_YEAR] = 1'b1;
      if (day_acc < 1 || day_acc > mlen) fl[dsdd_pkg::FLAG_DAY] = 1'b1;
      if (total > COUNT_CEIL) total = COUNT_CEIL;
      return total;
    endfunction

    // One accepted character.
    function void note_char(logic [7:0] c, logic last);
      int unsigned dig, total;
      logic [dsdd_pkg::FLAGS_W-1:0] fl;
      if (c == dsdd_pkg::CH_SLASH || c == dsdd_pkg::CH_DASH) begin
        if (field != dsdd_pkg::FIELD_YEAR) begin
          field = field + 1'b1;
          ndigits = 0;
        end
      end else if (c >= dsdd_pkg::CH_ZERO && c <= dsdd_pkg::CH_NINE) begin
        dig = c - dsdd_pkg::CH_ZERO;
        case (field)
          dsdd_pkg::FIELD_DAY: if (ndigits < dsdd_pkg::DAY_DIGITS) begin
            day_acc = day_acc * 10 + dig;
            ndigits++;
          end
          dsdd_pkg::FIELD_MONTH: if (ndigits < dsdd_pkg::MONTH_DIGITS) begin
            month_acc = month_acc * 10 + dig;
            ndigits++;
          end
          default: if (ndigits < dsdd_pkg::YEAR_DIGITS) begin
            year_acc = year_acc * 10 + dig;
            ndigits++;
          end
        endcase
      end
      if (!last) return;
      total = date_total(fl);
      clear_fields();
      if (!in_second) begin
        first_total = total;
        flags_acc = fl;
        in_second = 1'b1;
      end else begin
        diff_q.push_back(dsdd_pkg::DIFF_W'(total - first_total));
        flags_q.push_back(flags_acc | fl);
        in_second = 1'b0;
        first_total = 0;
        flags_acc = '0;
      end
    endfunction

    // One accepted result against the oldest expectation.
    function void check_result(logic [dsdd_pkg::DIFF_W-1:0] diff,
                               logic [dsdd_pkg::FLAGS_W-1:0] fl);
      logic [dsdd_pkg::DIFF_W-1:0] want_diff;
      logic [dsdd_pkg::FLAGS_W-1:0] want_fl;
      if (diff_q.size() == 0) begin
        $error("unexpected result: day_difference %0d error_flags %0d", $signed(diff), fl);
        errors++;
        return;
      end
      want_diff = diff_q.pop_front();
      want_fl = flags_q.pop_front();
      checked++;
      if (diff !== want_diff) begin
        $error("day_difference: expected %0d, got %0d", $signed(want_diff), $signed(diff));
        errors++;
      end
      if (fl !== want_fl) begin
        $error("error_flags: expected %0d, got %0d", want_fl, fl);
        errors++;
      end
    endfunction

    function int pending();
      return diff_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] ch;
  logic end_of_date;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [dsdd_pkg::DIFF_W-1:0] day_difference;
  logic [dsdd_pkg::FLAGS_W-1:0] error_flags;

  day_diff_scoreboard sb = new();
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int chars_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  date_string_day_difference DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .ch             (ch),
    .end_of_date    (end_of_date),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .day_difference (day_difference),
    .error_flags    (error_flags)
  );

  // Receiver backpressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Observe both handshakes.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_char(ch, end_of_date);
    if (!rst && out_valid && out_ready) sb.check_result(day_difference, error_flags);
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("[date_string_day_difference] ERROR");
      $finish;
    end
  end

  // Send one character; each cycle before it is idle with the gap odds.
  task automatic send_char(input logic [7:0] c, input logic last);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    end_of_date <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Random bytes ending a date: junk, stray digits and separators.
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // Hold the sender until every owed result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly well-formed date text with random content and some defects.
  function automatic string rand_date_text();
    int d, m, y, sel;
    string s, sep_a, sep_b, ds, ms;
    sel = $urandom_range(99);
    if (sel < 60) d = $urandom_range(1, 28);
    else if (sel < 88) d = $urandom_range(29, 31);
    else d = $urandom_range(0, 99);
    m = ($urandom_range(99) < 92) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    sel = $urandom_range(99);
    if (sel < 40) y = $urandom_range(1, 2100);
    else if (sel < 60) y = 4 * $urandom_range(0, 2500);
    else if (sel < 90) y = $urandom_range(1, 10000);
    else y = $urandom_range(0, 99999);
    sep_a = $urandom_range(1) ? "/" : "-";
    sep_b = $urandom_range(1) ? "/" : "-";
    ds = $urandom_range(1) ? $sformatf("%0d", d) : $sformatf("%02d", d);
    ms = $urandom_range(1) ? $sformatf("%0d", m) : $sformatf("%02d", m);
    s = {ds, sep_a, ms, sep_b, $sformatf("%0d", y)};
    sel = $urandom_range(99);
    if (sel < 4) s = {s, $sformatf("%0d", $urandom_range(0, 999))};
    else if (sel < 8) s = {" ", s};
    else if (sel < 11) s = {s, sep_a};
    else if (sel < 13) s = {sep_a, ms, sep_b};
    else if (sel < 15) s = {ds, "x", sep_a, ms, sep_b, "0", $sformatf("%0d", y)};
    return s;
  endfunction

  initial begin
    int target;
    rst = 1'b1;
    in_valid = 1'b0;
    ch = 8'h00;
    end_of_date = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: leap day vs. largest good date, all flags vs. saturated count, two equal dates.
    send_text("29-2-4");
    send_text("31/12/10000");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("//-");
    send_text("999/99/999999");
    send_text("1/1/1");
    send_text("1-1-1");
    drain();

    // Random traffic under four idle/stall mixes.
    target = chars_sent;
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 74; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 74; end
        default: begin send_gap_pct = 17; recv_stall_pct = 17; end
      endcase
      target += CHARS_PER_MIX;
      while (chars_sent < target) begin
        if ($urandom_range(99) < 10) send_noise();
        else send_text(rand_date_text());
      end
      drain();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d characters over four idle/stall mixes; %0d day differences checked.",
             chars_sent, sb.checked);
    $display("Mismatches found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("[date_string_day_difference] OK");
    end else begin
      $display("[date_string_day_difference] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dsdd_pkg.sv
src/dsdd_parser.sv
src/dsdd_fifo.sv
src/dsdd_counter.sv
src/date_string_day_difference.sv
tb/tb.sv
